[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL of the RGB to HSV converter.
// Both macros expect signals named clock and reset in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition cons must hold in the same cycle as ante.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rgbhsv_pkg.sv]
// Package for the RGB to HSV converter: register map constants and the
// control bundle passed along the divider chain. No dependencies.
package rgbhsv_pkg;

   localparam int THRESH_BITS   = 8;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // Register index, taken from the word address bits of paddr.
   localparam logic [0:0] REG_ACHROMATIC_THRESHOLD = 1'b0;

   typedef struct packed {
      logic valid;
      logic achromatic;
      logic black;
   } ctl_type;

endpackage

[rtl/rgbhsv_cell.sv]
// One cell of the divider chain: a single restoring step for the hue
// division and one for the saturation division. Depends on rgbhsv_pkg.
module rgbhsv_cell
   import rgbhsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ready_dn,
   output logic                    ready_up,
   input  ctl_type                 src_ctl,
   input  logic [CHANNEL_BITS+2:0] src_rem_h,
   input  logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] src_low_h,
   input  logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] src_quo_h,
   input  logic [CHANNEL_BITS+2:0] src_div_h,
   input  logic [CHANNEL_BITS-1:0] src_rem_s,
   input  logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] src_low_s,
   input  logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] src_quo_s,
   input  logic [CHANNEL_BITS-1:0] src_bright,
   input  logic [HUE_BITS-1:0]     src_fallback,
   output ctl_type                 dst_ctl,
   output logic [CHANNEL_BITS+2:0] dst_rem_h,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_low_h,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_quo_h,
   output logic [CHANNEL_BITS+2:0] dst_div_h,
   output logic [CHANNEL_BITS-1:0] dst_rem_s,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_low_s,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_quo_s,
   output logic [CHANNEL_BITS-1:0] dst_bright,
   output logic [HUE_BITS-1:0]     dst_fallback
);

   localparam int STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
   localparam int RH    = CHANNEL_BITS + 3;
   localparam int RS    = CHANNEL_BITS;

   logic [RH:0]        trial_h;
   logic [RH+1:0]      diff_h;
   logic               bit_h;
   logic [RS:0]        trial_s;
   logic [RS+1:0]      diff_s;
   logic               bit_s;
   logic               load;

   ctl_type            ctl_ff;
   logic [RH-1:0]      rem_h_ff, rem_h_in, div_h_ff;
   logic [STEPS-1:0]   low_h_ff, low_h_in, quo_h_ff, quo_h_in;
   logic [RS-1:0]      rem_s_ff, rem_s_in, bright_ff;
   logic [STEPS-1:0]   low_s_ff, low_s_in, quo_s_ff, quo_s_in;
   logic [HUE_BITS-1:0] fallback_ff;

   // Shift the next dividend bit into the partial remainder and try the divisor.
   always_comb begin
      trial_h  = {src_rem_h, src_low_h[STEPS-1]};
      diff_h   = {1'b0, trial_h} - {2'b00, src_div_h};
      bit_h    = ~diff_h[RH+1];
      rem_h_in = bit_h ? diff_h[RH-1:0] : trial_h[RH-1:0];
      low_h_in = {src_low_h[STEPS-2:0], 1'b0};
      quo_h_in = {src_quo_h[STEPS-2:0], bit_h};

      trial_s  = {src_rem_s, src_low_s[STEPS-1]};
      diff_s   = {1'b0, trial_s} - {2'b00, src_bright};
      bit_s    = ~diff_s[RS+1];
      rem_s_in = bit_s ? diff_s[RS-1:0] : trial_s[RS-1:0];
      low_s_in = {src_low_s[STEPS-2:0], 1'b0};
      quo_s_in = {src_quo_s[STEPS-2:0], bit_s};
   end

   assign load     = ~ctl_ff.valid | ready_dn;
   assign ready_up = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= src_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_h_ff    <= rem_h_in;
         low_h_ff    <= low_h_in;
         quo_h_ff    <= quo_h_in;
         div_h_ff    <= src_div_h;
         rem_s_ff    <= rem_s_in;
         low_s_ff    <= low_s_in;
         quo_s_ff    <= quo_s_in;
         bright_ff   <= src_bright;
         fallback_ff <= src_fallback;
      end
   end

   assign dst_ctl      = ctl_ff;
   assign dst_rem_h    = rem_h_ff;
   assign dst_low_h    = low_h_ff;
   assign dst_quo_h    = quo_h_ff;
   assign dst_div_h    = div_h_ff;
   assign dst_rem_s    = rem_s_ff;
   assign dst_low_s    = low_s_ff;
   assign dst_quo_s    = quo_s_ff;
   assign dst_bright   = bright_ff;
   assign dst_fallback = fallback_ff;

endmodule

[rtl/rgbhsv_front.sv]
// Entry stage of the RGB to HSV converter: maximum, minimum, spread, grey
// test and the two dividends and divisors for the chain. Depends on rgbhsv_pkg.
module rgbhsv_front
   import rgbhsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    src_valid,
   output logic                    ready_up,
   input  logic                    ready_dn,
   input  logic [CHANNEL_BITS-1:0] red,
   input  logic [CHANNEL_BITS-1:0] green,
   input  logic [CHANNEL_BITS-1:0] blue,
   input  logic [HUE_BITS-1:0]     fallback_hue,
   input  logic [THRESH_BITS-1:0]  threshold,
   output ctl_type                 dst_ctl,
   output logic [CHANNEL_BITS+2:0] dst_rem_h,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_low_h,
   output logic [CHANNEL_BITS+2:0] dst_div_h,
   output logic [CHANNEL_BITS-1:0] dst_rem_s,
   output logic [((HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS)-1:0] dst_low_s,
   output logic [CHANNEL_BITS-1:0] dst_bright,
   output logic [HUE_BITS-1:0]     dst_fallback
);

   localparam int STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
   localparam int RH    = CHANNEL_BITS + 3;
   localparam int YW    = RH + STEPS;
   localparam int XW    = CHANNEL_BITS + STEPS;
   localparam int CMPW  = (CHANNEL_BITS > THRESH_BITS) ? CHANNEL_BITS : THRESH_BITS;

   logic [CHANNEL_BITS-1:0] mx, mn, spread;
   logic [RH-1:0]           spread_w, spread6, num;
   logic [YW-1:0]           hue_dividend;
   logic [XW-1:0]           sat_dividend;
   ctl_type                 ctl_in;
   logic                    load;

   ctl_type                 ctl_ff;
   logic [RH-1:0]           rem_h_ff, div_h_ff;
   logic [STEPS-1:0]        low_h_ff, low_s_ff;
   logic [CHANNEL_BITS-1:0] rem_s_ff, bright_ff;
   logic [HUE_BITS-1:0]     fallback_ff;

   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      spread   = mx - mn;
      spread_w = RH'(spread);
      spread6  = (spread_w << 2) + (spread_w << 1);

      // Sector numerator; a red-sector value below zero is wrapped by a full turn.
      if (red == mx) begin
         if (green >= blue) begin
            num = RH'(green) - RH'(blue);
         end else begin
            num = spread6 - (RH'(blue) - RH'(green));
         end
      end else if (green == mx) begin
         num = (spread_w << 1) + RH'(blue) - RH'(red);
      end else begin
         num = (spread_w << 2) + RH'(red) - RH'(green);
      end

      hue_dividend = YW'(num) << HUE_BITS;
      // Spread times full scale, written as spread shifted up less spread.
      sat_dividend = XW'({spread, {CHANNEL_BITS{1'b0}}}) - XW'(spread);

      ctl_in.valid      = src_valid;
      ctl_in.achromatic = (CMPW'(spread) <= CMPW'(threshold)) || (spread == '0);
      ctl_in.black      = (mx == '0);
   end

   assign load     = ~ctl_ff.valid | ready_dn;
   assign ready_up = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_h_ff    <= hue_dividend[YW-1:STEPS];
         low_h_ff    <= hue_dividend[STEPS-1:0];
         div_h_ff    <= spread6;
         rem_s_ff    <= sat_dividend[XW-1:STEPS];
         low_s_ff    <= sat_dividend[STEPS-1:0];
         bright_ff   <= mx;
         fallback_ff <= fallback_hue;
      end
   end

   assign dst_ctl      = ctl_ff;
   assign dst_rem_h    = rem_h_ff;
   assign dst_low_h    = low_h_ff;
   assign dst_div_h    = div_h_ff;
   assign dst_rem_s    = rem_s_ff;
   assign dst_low_s    = low_s_ff;
   assign dst_bright   = bright_ff;
   assign dst_fallback = fallback_ff;

endmodule

[rtl/rgb_to_hsv_converter.sv]
// Top level of the RGB to HSV converter: register port, entry stage and the
// row of divider cells. Depends on rgbhsv_pkg, rgbhsv_front, rgbhsv_cell, assert_macros.svh.
//
// A request carries one pixel (red, green, blue) and the hue to report for a
// grey pixel. The response gives hue as a fraction of a turn, saturation,
// brightness and a flag that marks grey pixels. A pixel is grey when its
// spread (max - min) is zero or does not exceed achromatic_threshold, the only
// register, at byte address 0 of the APB port (reset value 0).
// The entry stage is followed by one divider cell for each quotient bit,
// max(HUE_BITS, CHANNEL_BITS) of them; each cell takes one restoring step of
// both the hue and the saturation division. A request passes the entry
// register and then every cell register before its response is offered,
// and one request is taken every cycle while the stages are not all full.
// When the receiver stalls, the last cell holds its response and the
// stages behind it keep filling; requests are refused only once every stage
// holds a pixel. Reset empties all stages and clears the register.
`include "assert_macros.svh"

module rgb_to_hsv_converter
   import rgbhsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CHANNEL_BITS-1:0]  req_red,
   input  logic [CHANNEL_BITS-1:0]  req_green,
   input  logic [CHANNEL_BITS-1:0]  req_blue,
   input  logic [HUE_BITS-1:0]      req_fallback_hue,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [HUE_BITS-1:0]      rsp_hue,
   output logic [CHANNEL_BITS-1:0]  rsp_saturation,
   output logic [CHANNEL_BITS-1:0]  rsp_brightness,
   output logic                     rsp_achromatic,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int STEPS = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
   localparam int RH    = CHANNEL_BITS + 3;

   logic [THRESH_BITS-1:0]  threshold_ff;
   logic                    reg_hit;

   logic                    ready_w    [STEPS+2];
   ctl_type                 ctl_w      [STEPS+1];
   logic [RH-1:0]           rem_h_w    [STEPS+1];
   logic [STEPS-1:0]        low_h_w    [STEPS+1];
   logic [STEPS-1:0]        quo_h_w    [STEPS+1];
   logic [RH-1:0]           div_h_w    [STEPS+1];
   logic [CHANNEL_BITS-1:0] rem_s_w    [STEPS+1];
   logic [STEPS-1:0]        low_s_w    [STEPS+1];
   logic [STEPS-1:0]        quo_s_w    [STEPS+1];
   logic [CHANNEL_BITS-1:0] bright_w   [STEPS+1];
   logic [HUE_BITS-1:0]     fallback_w [STEPS+1];

   // Register port.
   assign reg_hit = (paddr[CSR_ADDR_BITS-1:2] == REG_ACHROMATIC_THRESHOLD);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? CSR_DATA_BITS'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         threshold_ff <= pwdata[THRESH_BITS-1:0];
      end
   end

   rgbhsv_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .HUE_BITS     (HUE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .src_valid    (req_valid),
      .ready_up     (ready_w[0]),
      .ready_dn     (ready_w[1]),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .fallback_hue (req_fallback_hue),
      .threshold    (threshold_ff),
      .dst_ctl      (ctl_w[0]),
      .dst_rem_h    (rem_h_w[0]),
      .dst_low_h    (low_h_w[0]),
      .dst_div_h    (div_h_w[0]),
      .dst_rem_s    (rem_s_w[0]),
      .dst_low_s    (low_s_w[0]),
      .dst_bright   (bright_w[0]),
      .dst_fallback (fallback_w[0])
   );

   // Quotients start empty and gain one bit in each cell.
   assign quo_h_w[0] = '0;
   assign quo_s_w[0] = '0;

   for (genvar k = 1; k <= STEPS; k++) begin : g_cell
      rgbhsv_cell #(
         .CHANNEL_BITS (CHANNEL_BITS),
         .HUE_BITS     (HUE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ready_dn     (ready_w[k+1]),
         .ready_up     (ready_w[k]),
         .src_ctl      (ctl_w[k-1]),
         .src_rem_h    (rem_h_w[k-1]),
         .src_low_h    (low_h_w[k-1]),
         .src_quo_h    (quo_h_w[k-1]),
         .src_div_h    (div_h_w[k-1]),
         .src_rem_s    (rem_s_w[k-1]),
         .src_low_s    (low_s_w[k-1]),
         .src_quo_s    (quo_s_w[k-1]),
         .src_bright   (bright_w[k-1]),
         .src_fallback (fallback_w[k-1]),
         .dst_ctl      (ctl_w[k]),
         .dst_rem_h    (rem_h_w[k]),
         .dst_low_h    (low_h_w[k]),
         .dst_quo_h    (quo_h_w[k]),
         .dst_div_h    (div_h_w[k]),
         .dst_rem_s    (rem_s_w[k]),
         .dst_low_s    (low_s_w[k]),
         .dst_quo_s    (quo_s_w[k]),
         .dst_bright   (bright_w[k]),
         .dst_fallback (fallback_w[k])
      );
   end

   assign ready_w[STEPS+1] = rsp_ready;
   assign req_ready        = ready_w[0];

   // The last cell doubles as the output register.
   assign rsp_valid      = ctl_w[STEPS].valid;
   assign rsp_achromatic = ctl_w[STEPS].achromatic;
   assign rsp_brightness = bright_w[STEPS];
   assign rsp_hue        = ctl_w[STEPS].achromatic ? fallback_w[STEPS]
                                                   : quo_h_w[STEPS][HUE_BITS-1:0];
   assign rsp_saturation = ctl_w[STEPS].black ? '0 : quo_s_w[STEPS][CHANNEL_BITS-1:0];

   `ASSERT_IMPLIES(a_refuse_only_when_full, !req_ready, rsp_valid && !rsp_ready, "request refused while the output is free")
   `ASSERT_IMPLIES(a_colour_has_saturation, rsp_valid && !rsp_achromatic, rsp_saturation != '0, "coloured pixel with zero saturation")
   `ASSERT_IMPLIES(a_black_is_grey, rsp_valid && (rsp_brightness == '0), (rsp_saturation == '0) && rsp_achromatic, "black pixel not reported as grey")

endmodule

[bench/hsv_result_checker.sv]
// Checker for the RGB to HSV converter: watches requests, responses and APB
// register writes and reads, predicts each response and compares it field
// by field. Depends on rgbhsv_pkg for the register map.
module hsv_result_checker
   import rgbhsv_pkg::*;
#(
   parameter int CHANNEL_BITS = 8,
   parameter int HUE_BITS     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [CHANNEL_BITS-1:0]  req_red,
   input  logic [CHANNEL_BITS-1:0]  req_green,
   input  logic [CHANNEL_BITS-1:0]  req_blue,
   input  logic [HUE_BITS-1:0]      req_fallback_hue,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [HUE_BITS-1:0]      rsp_hue,
   input  logic [CHANNEL_BITS-1:0]  rsp_saturation,
   input  logic [CHANNEL_BITS-1:0]  rsp_brightness,
   input  logic                     rsp_achromatic,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic [CSR_DATA_BITS-1:0] prdata,
   input  logic                     pready,
   output int                       mismatch_count,
   output int                       pixels_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [HUE_BITS-1:0]     hue;
      logic [CHANNEL_BITS-1:0] saturation;
      logic [CHANNEL_BITS-1:0] brightness;
      logic                    achromatic;
   } hsv_result_type;

   localparam longint unsigned CHAN_FULL = (64'd1 << CHANNEL_BITS) - 1;

   logic [THRESH_BITS-1:0] grey_spread_limit = '0;
   hsv_result_type         expected_hsv [$];

   initial begin
      mismatch_count   = 0;
      pixels_in_flight = 0;
   end

   function automatic hsv_result_type convert_pixel(input logic [CHANNEL_BITS-1:0] r,
                                                    input logic [CHANNEL_BITS-1:0] g,
                                                    input logic [CHANNEL_BITS-1:0] b,
                                                    input logic [HUE_BITS-1:0] fallback,
                                                    input logic [THRESH_BITS-1:0] limit);
      longint unsigned top, bottom, spread, turn_part;
      hsv_result_type  res;
      top    = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      spread = top - bottom;
      res.brightness = top[CHANNEL_BITS-1:0];
      res.saturation = (top == 0) ? '0 : CHANNEL_BITS'((spread * CHAN_FULL) / top);
      if (spread == 0 || spread <= limit) begin
         res.hue        = fallback;
         res.achromatic = 1'b1;
      end else begin
         res.achromatic = 1'b0;
         // Sector order red, green, blue settles ties; red wraps below zero.
         if (top == r) begin
            if (g >= b) turn_part = g - b;
            else turn_part = 6 * spread - (b - g);
         end else if (top == g) begin
            turn_part = 2 * spread + b - r;
         end else begin
            turn_part = 4 * spread + r - g;
         end
         res.hue = HUE_BITS'((turn_part << HUE_BITS) / (6 * spread));
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      hsv_result_type want;
      int             bad;
      bad = 0;
      if (reset) begin
         expected_hsv.delete();
         grey_spread_limit <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_hsv.size() == 0) begin
               $error("response with no request outstanding: hue %0d", rsp_hue);
               bad++;
            end else begin
               want = expected_hsv.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
                  bad++;
               end
               if (rsp_saturation !== want.saturation) begin
                  $error("saturation: expected %0d, got %0d", want.saturation,
                         rsp_saturation);
                  bad++;
               end
               if (rsp_brightness !== want.brightness) begin
                  $error("brightness: expected %0d, got %0d", want.brightness,
                         rsp_brightness);
                  bad++;
               end
               if (rsp_achromatic !== want.achromatic) begin
                  $error("achromatic: expected %0d, got %0d", want.achromatic,
                         rsp_achromatic);
                  bad++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_hsv.push_back(convert_pixel(req_red, req_green, req_blue,
                                                 req_fallback_hue, grey_spread_limit));
         if (psel && penable && pready && paddr[CSR_ADDR_BITS-1:2] == REG_ACHROMATIC_THRESHOLD)
         begin
            if (pwrite) begin
               grey_spread_limit <= pwdata[THRESH_BITS-1:0];
            end else if (prdata !== CSR_DATA_BITS'(grey_spread_limit)) begin
               $error("achromatic_threshold: expected %0d, got %0d", grey_spread_limit,
                      prdata);
               bad++;
            end
         end
      end
      mismatch_count   <= mismatch_count + bad;
      pixels_in_flight <= expected_hsv.size();
   end

endmodule

[bench/tb.sv]
// Top of the RGB to HSV converter testbench: clock, reset, request and
// response traffic, APB register writes and read-backs, and the verdict.
// Depends on rgbhsv_pkg, rgb_to_hsv_converter and hsv_result_checker.
module tb
   import rgbhsv_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHANNEL_BITS = 8;
   localparam int HUE_BITS     = 16;
   localparam int CHAN_MAX     = (1 << CHANNEL_BITS) - 1;
   localparam int NUM_CHUNKS   = 6;
   localparam int CHUNK_ITEMS  = 215;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_NEAR_LIMIT,
      SHAPE_TIE,
      SHAPE_GREY,
      SHAPE_CORNER
   } pixel_shape_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CHANNEL_BITS-1:0]  req_red;
   logic [CHANNEL_BITS-1:0]  req_green;
   logic [CHANNEL_BITS-1:0]  req_blue;
   logic [HUE_BITS-1:0]      req_fallback_hue;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [HUE_BITS-1:0]      rsp_hue;
   logic [CHANNEL_BITS-1:0]  rsp_saturation;
   logic [CHANNEL_BITS-1:0]  rsp_brightness;
   logic                     rsp_achromatic;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   int fail_count;
   int pending;
   int send_idle_pct;
   int recv_stall_pct;

   rgb_to_hsv_converter #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .HUE_BITS    (HUE_BITS)
   ) dut (.*);

   hsv_result_checker #(
      .CHANNEL_BITS(CHANNEL_BITS),
      .HUE_BITS    (HUE_BITS)
   ) result_check (
      .*,
      .mismatch_count  (fail_count),
      .pixels_in_flight(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                             input logic [CHANNEL_BITS-1:0] g,
                             input logic [CHANNEL_BITS-1:0] b,
                             input logic [HUE_BITS-1:0] fallback);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_red          <= r;
      req_green        <= g;
      req_blue         <= b;
      req_fallback_hue <= fallback;
      do @(posedge clock); while (!req_ready);
   endtask

   // Holds the request channel quiet until every response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_threshold(input logic [THRESH_BITS-1:0] limit);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_ACHROMATIC_THRESHOLD, 2'b00};
      pwdata  <= CSR_DATA_BITS'(limit);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      // Read the register straight back; the checker compares prdata.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_pixel(input logic [THRESH_BITS-1:0] limit);
      logic [CHANNEL_BITS-1:0] ch [3];
      logic [HUE_BITS-1:0]     fallback;
      pixel_shape_type         shape;
      int                      pick, spread, low, hi_idx, lo_idx, mid_idx;
      pick = $urandom_range(0, 99);
      if (pick < 45) shape = SHAPE_ANY;
      else if (pick < 70) shape = SHAPE_NEAR_LIMIT;
      else if (pick < 85) shape = SHAPE_TIE;
      else if (pick < 90) shape = SHAPE_GREY;
      else shape = SHAPE_CORNER;
      hi_idx  = $urandom_range(0, 2);
      lo_idx  = (hi_idx + 1 + $urandom_range(0, 1)) % 3;
      mid_idx = 3 - hi_idx - lo_idx;
      case (shape)
         SHAPE_NEAR_LIMIT: begin
            // Spread lands on the grey limit or one above it.
            spread = int'(limit) + $urandom_range(0, 1);
            if (spread > CHAN_MAX) spread = CHAN_MAX;
            low = $urandom_range(0, CHAN_MAX - spread);
            ch[hi_idx]  = CHANNEL_BITS'(low + spread);
            ch[lo_idx]  = CHANNEL_BITS'(low);
            ch[mid_idx] = CHANNEL_BITS'($urandom_range(low, low + spread));
         end
         SHAPE_TIE: begin
            ch[hi_idx]  = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
            ch[mid_idx] = ch[hi_idx];
            ch[lo_idx]  = CHANNEL_BITS'($urandom_range(0, int'(ch[hi_idx])));
         end
         SHAPE_GREY: begin
            ch[0] = CHANNEL_BITS'($urandom_range(0, CHAN_MAX));
            ch[1] = ch[0];
            ch[2] = ch[0];
         end
         SHAPE_CORNER: begin
            foreach (ch[i]) begin
               case ($urandom_range(0, 3))
                  0: ch[i] = '0;
                  1: ch[i] = CHANNEL_BITS'(1);
                  2: ch[i] = CHANNEL_BITS'(CHAN_MAX - 1);
                  default: ch[i] = CHANNEL_BITS'(CHAN_MAX);
               endcase
            end
         end
         default: begin
            foreach (ch[i]) ch[i] = CHANNEL_BITS'($urandom());
         end
      endcase
      case ($urandom_range(0, 9))
         0: fallback = '0;
         1: fallback = '1;
         default: fallback = HUE_BITS'($urandom());
      endcase
      send_pixel(ch[0], ch[1], ch[2], fallback);
   endtask

   initial begin
      logic [THRESH_BITS-1:0] limit;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_red          = '0;
      req_green        = '0;
      req_blue         = '0;
      req_fallback_hue = '0;
      rsp_ready        = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      send_idle_pct    = 19;
      recv_stall_pct   = 51;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_threshold('0);
      // Black, white, primaries, ties between maxima, red-sector wrap,
      // smallest spreads and the extremes of the fallback hue.
      send_pixel(8'd0,   8'd0,   8'd0,   16'h0000);
      send_pixel(8'd0,   8'd0,   8'd0,   16'hFFFF);
      send_pixel(8'd255, 8'd255, 8'd255, 16'h5A5A);
      send_pixel(8'd255, 8'd0,   8'd0,   16'hFFFF);
      send_pixel(8'd0,   8'd255, 8'd0,   16'h0000);
      send_pixel(8'd0,   8'd0,   8'd255, 16'hFFFF);
      send_pixel(8'd255, 8'd255, 8'd0,   16'h1234);
      send_pixel(8'd0,   8'd255, 8'd255, 16'h1234);
      send_pixel(8'd255, 8'd0,   8'd255, 16'h1234);
      send_pixel(8'd255, 8'd0,   8'd10,  16'h0000);
      send_pixel(8'd255, 8'd10,  8'd0,   16'h0000);
      send_pixel(8'd10,  8'd255, 8'd0,   16'h0000);
      send_pixel(8'd0,   8'd255, 8'd10,  16'h0000);
      send_pixel(8'd10,  8'd0,   8'd255, 16'h0000);
      send_pixel(8'd0,   8'd10,  8'd255, 16'h0000);
      send_pixel(8'd1,   8'd0,   8'd0,   16'hFFFF);
      send_pixel(8'd0,   8'd1,   8'd0,   16'hFFFF);
      send_pixel(8'd0,   8'd0,   8'd1,   16'hFFFF);
      send_pixel(8'd128, 8'd129, 8'd128, 16'h8000);
      send_pixel(8'd254, 8'd1,   8'd127, 16'h7FFF);
      drain();

      for (int chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
         case (chunk)
            0: limit = '1;
            1: limit = THRESH_BITS'(1);
            3: limit = '0;
            default: limit = THRESH_BITS'($urandom_range(0, 255));
         endcase
         write_threshold(limit);
         case (chunk / 2)
            0: begin
               send_idle_pct  = 19;
               recv_stall_pct = 51;
            end
            1: begin
               send_idle_pct  = 51;
               recv_stall_pct = 19;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < CHUNK_ITEMS; n++)
            send_random_pixel(limit);
         drain();
      end

      repeat (25) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_cell.sv
rtl/rgbhsv_front.sv
rtl/rgb_to_hsv_converter.sv
bench/hsv_result_checker.sv
bench/tb.sv
